/* src/ipv4_wildcard_best_match_table_macros.svh */
// assertion macros shared by the table rtl
`ifndef IPV4_WILDCARD_BEST_MATCH_TABLE_MACROS_SVH
`define IPV4_WILDCARD_BEST_MATCH_TABLE_MACROS_SVH

// same-cycle implication, reset masked
`define IWBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define IWBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/iwbm_pkg.sv */
// shared types, constants and scoring functions for the ipv4 wildcard table
package iwbm_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int OctW       = 8;
  localparam int NumOct     = 4;
  localparam int AddrW      = OctW * NumOct;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 48;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  localparam logic [2:0] SCORE_MAX = 3'd4;

  typedef struct packed {
    logic [AddrW-1:0]  octets;
    logic [NumOct-1:0] wild;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // leading octets that agree, wildcard on either side agrees
  function automatic logic [2:0] score_entry(entry_t e, logic [AddrW-1:0] qa,
                                             logic [NumOct-1:0] qw);
    logic [2:0] s;
    logic       hit;
    s   = SCORE_MAX;
    hit = 1'b0;
    for (int k = 0; k < NumOct; k++) begin
      if (!hit && !e.wild[NumOct-1-k] && !qw[NumOct-1-k] &&
          e.octets[AddrW-1-OctW*k -: OctW] != qa[AddrW-1-OctW*k -: OctW]) begin
        s   = 3'(k);
        hit = 1'b1;
      end
    end
    return s;
  endfunction

  // exact pattern equality, stored value of a wildcard octet ignored
  function automatic logic same_pattern(entry_t e, logic [AddrW-1:0] qa,
                                        logic [NumOct-1:0] qw);
    logic eq;
    eq = (e.wild == qw);
    for (int k = 0; k < NumOct; k++) begin
      if (!qw[NumOct-1-k] &&
          e.octets[AddrW-1-OctW*k -: OctW] != qa[AddrW-1-OctW*k -: OctW]) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

endpackage

/* src/iwbm_ram.sv */
// generic single-write, single-read ram with registered read data
module iwbm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ipv4_wildcard_best_match_table.sv */
// ipv4 wildcard pattern table with add, exact remove and best-match lookup
//
//   channel | dir | tdata fields (low bit up)                          | tlast | tuser
//   in_     | in  | op[1:0] address[33:2] wild_mask[37:34], pad to 40  | -     | -
//   out_    | out | status[1:0] score[4:2] match_address[36:5]
//           |     | match_wild[40:37], pad to 48                       | -     | -
//
// add: result register written on the transaction itself, free slot found by a priority encoder
// remove and lookup: one table entry per cycle through the ram read port,
// remove ends early at the first hit
// in_tready is high only in idle; a waiting result does not block the next transaction
// rst_n clears the slot valid bits and the sequencer, ram contents are left as they are
`include "ipv4_wildcard_best_match_table_macros.svh"

module ipv4_wildcard_best_match_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [iwbm_pkg::InDataW-1:0]    in_tdata,   // op, address, wild_mask
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [iwbm_pkg::OutDataW-1:0]   out_tdata   // status, score, match_address, match_wild
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } state_t;

  state_t                           state_r, state_nxt;
  logic [iwbm_pkg::TableDepth-1:0]  valid_r, valid_nxt;
  logic [iwbm_pkg::CntW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [iwbm_pkg::IdxW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                             cmp_vld_r, cmp_vld_nxt;
  logic                             found_r, found_nxt;
  logic [1:0]                       q_op_r, q_op_nxt;
  logic [iwbm_pkg::AddrW-1:0]       q_addr_r, q_addr_nxt;
  logic [iwbm_pkg::NumOct-1:0]      q_wild_r, q_wild_nxt;
  logic [1:0]                       res_status_r, res_status_nxt;
  logic [2:0]                       res_score_r, res_score_nxt;
  logic [iwbm_pkg::AddrW-1:0]       res_addr_r, res_addr_nxt;
  logic [iwbm_pkg::NumOct-1:0]      res_wild_r, res_wild_nxt;
  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [iwbm_pkg::OutDataW-1:0]    out_tdata_r, out_tdata_nxt;

  logic                             in_fire;
  logic [1:0]                       in_op;
  logic [iwbm_pkg::AddrW-1:0]       in_addr;
  logic [iwbm_pkg::NumOct-1:0]      in_wild;
  logic                             any_free;
  logic [iwbm_pkg::IdxW-1:0]        free_idx;
  logic                             ram_we;
  iwbm_pkg::entry_t                 ram_wdata;
  iwbm_pkg::entry_t                 ram_rdata;
  logic [iwbm_pkg::EntryW-1:0]      ram_rdata_raw;
  logic [2:0]                       cur_score;
  logic                             cur_same;
  logic                             cmp_last;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign in_op     = in_tdata[1:0];
  assign in_addr   = in_tdata[33:2];
  assign in_wild   = in_tdata[37:34];

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = iwbm_pkg::TableDepth - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        any_free = 1'b1;
        free_idx = iwbm_pkg::IdxW'(i);
      end
    end
  end

  assign ram_we    = in_fire && (in_op == iwbm_pkg::OP_ADD) && any_free;
  assign ram_wdata = '{octets: in_addr, wild: in_wild};
  assign ram_rdata = iwbm_pkg::entry_t'(ram_rdata_raw);

  iwbm_ram #(
    .WIDTH (iwbm_pkg::EntryW),
    .DEPTH (iwbm_pkg::TableDepth)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[iwbm_pkg::IdxW-1:0]),
    .rdata (ram_rdata_raw)
  );

  assign cur_score = iwbm_pkg::score_entry(ram_rdata, q_addr_r, q_wild_r);
  assign cur_same  = iwbm_pkg::same_pattern(ram_rdata, q_addr_r, q_wild_r);
  assign cmp_last  = (cmp_idx_r == iwbm_pkg::IdxW'(iwbm_pkg::TableDepth - 1));

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    found_nxt      = found_r;
    q_op_nxt       = q_op_r;
    q_addr_nxt     = q_addr_r;
    q_wild_nxt     = q_wild_r;
    res_status_nxt = res_status_r;
    res_score_nxt  = res_score_r;
    res_addr_nxt   = res_addr_r;
    res_wild_nxt   = res_wild_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          q_op_nxt       = in_op;
          q_addr_nxt     = in_addr;
          q_wild_nxt     = in_wild;
          res_status_nxt = iwbm_pkg::STATUS_MISS;
          res_score_nxt  = '0;
          res_addr_nxt   = '0;
          res_wild_nxt   = '0;
          found_nxt      = 1'b0;
          rd_idx_nxt     = '0;
          cmp_vld_nxt    = 1'b0;
          case (in_op)
            iwbm_pkg::OP_ADD: begin
              if (any_free) begin
                valid_nxt[free_idx] = 1'b1;
                res_status_nxt      = iwbm_pkg::STATUS_DONE;
              end else begin
                res_status_nxt = iwbm_pkg::STATUS_FULL;
              end
              state_nxt = ST_PUSH;
            end
            iwbm_pkg::OP_REMOVE: state_nxt = ST_SCAN;
            iwbm_pkg::OP_LOOKUP: state_nxt = ST_SCAN;
            default:             state_nxt = ST_PUSH;
          endcase
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = (rd_idx_r < iwbm_pkg::CntW'(iwbm_pkg::TableDepth));
        cmp_idx_nxt = rd_idx_r[iwbm_pkg::IdxW-1:0];
        if (cmp_vld_nxt) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (cmp_last) begin
            state_nxt = ST_PUSH;
          end
          if (valid_r[cmp_idx_r]) begin
            if (q_op_r == iwbm_pkg::OP_REMOVE) begin
              if (cur_same) begin
                valid_nxt[cmp_idx_r] = 1'b0;
                res_status_nxt       = iwbm_pkg::STATUS_DONE;
                state_nxt            = ST_PUSH;
              end
            end else if (!found_r || cur_score > res_score_r) begin
              found_nxt      = 1'b1;
              res_status_nxt = iwbm_pkg::STATUS_DONE;
              res_score_nxt  = cur_score;
              res_addr_nxt   = ram_rdata.octets;
              res_wild_nxt   = ram_rdata.wild;
            end
          end
        end
      end
      ST_PUSH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = iwbm_pkg::OutDataW'({res_wild_r, res_addr_r,
                                                res_score_r, res_status_r});
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    found_r      <= found_nxt;
    q_op_r       <= q_op_nxt;
    q_addr_r     <= q_addr_nxt;
    q_wild_r     <= q_wild_nxt;
    res_status_r <= res_status_nxt;
    res_score_r  <= res_score_nxt;
    res_addr_r   <= res_addr_nxt;
    res_wild_r   <= res_wild_nxt;
    out_tdata_r  <= out_tdata_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      cmp_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  `IWBM_ASSERT_NEXT(a_add_takes_slot,
    in_fire && (in_op == iwbm_pkg::OP_ADD) && any_free,
    $countones(valid_r) == $countones($past(valid_r)) + 1,
    "add did not occupy exactly one slot")

  `IWBM_ASSERT_SAME(a_lookup_miss_empty,
    (state_r == ST_PUSH) && (q_op_r == iwbm_pkg::OP_LOOKUP) &&
      (res_status_r == iwbm_pkg::STATUS_MISS),
    valid_r == '0,
    "lookup missed on a non-empty table")

  `IWBM_ASSERT_SAME(a_score_range,
    out_tvalid_r,
    out_tdata_r[4:2] <= iwbm_pkg::SCORE_MAX,
    "score above octet count")

  `IWBM_ASSERT_NEXT(a_full_keeps_table,
    in_fire && (in_op == iwbm_pkg::OP_ADD) && !any_free,
    valid_r == $past(valid_r),
    "table changed on a full add")

endmodule
